/* src/hot_pkg.sv */
// Shared types and constants for the tile hit test block.
`timescale 1ns / 1ps
package hot_pkg;
  localparam int CB      = 16;                          // point coordinate width
  localparam int CFG_W   = 16;                          // widest config register
  localparam int DW      = ((CB > CFG_W) ? CB : CFG_W) + 2;
  localparam int NLANE   = 3;
  localparam int ROW_W   = 17;
  localparam int COL_W   = 18;
  localparam int ROW_MAX = 65535;
  localparam int COL_MAX = 131071;

  // divider lanes
  localparam int LN_ROW = 0;  // y/h, or 4y/3h for hexagons
  localparam int LN_C0  = 1;  // x/w
  localparam int LN_C1  = 2;  // (2x+w)/2w, odd hexagon rows

  // config register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [DW-1:0] num;
    logic [DW-1:0] quo;
  } hot_lane_t;

  typedef hot_lane_t [NLANE-1:0] hot_stage_t;

  typedef struct packed {
    logic             mode;
    logic [CFG_W-1:0] w;   // never zero
    logic [CFG_W-1:0] h;   // never zero
  } hot_cfg_t;
endpackage

/* src/hex_or_rect_tile_hit_test_top.sv */
// Top level of the rectangle / offset-hexagon tile hit test.
`timescale 1ns / 1ps
// Maps one point word per cycle to the row and column of the tile under it.
// The word passes a chain of division cells, one per quotient bit, that runs
// three dividers side by side, then the register of the edge cross products
// and the correction and output register. Throughput is one word per clock;
// the whole chain holds only while a finished word waits at the output under
// stall. Config writes must be made with no word in flight.
module hex_or_rect_tile_hit_test_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hot_pkg::CB-1:0]        in_point_x,
  input  logic [hot_pkg::CB-1:0]        in_point_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hot_pkg::ROW_W-1:0]     out_tile_row,
  output logic [hot_pkg::COL_W-1:0]     out_tile_col,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [hot_pkg::CFG_W-1:0]     cfg_wdata
);
  import hot_pkg::*;

  logic             mode_r;
  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;
  hot_cfg_t         cfg;
  logic             adv;
  logic             out_valid_w;

  logic [NLANE-1:0][DW-1:0] div;
  logic [DW:0]              vld;
  hot_stage_t [DW:0]        stg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      width_r  <= CFG_W'(256);
      height_r <= CFG_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   mode_r   <= cfg_wdata[0];
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // zero size acts as one
  assign cfg.mode = mode_r;
  assign cfg.w    = (width_r == '0) ? CFG_W'(1) : width_r;
  assign cfg.h    = (height_r == '0) ? CFG_W'(1) : height_r;

  assign out_valid = out_valid_w;

  assign adv      = !out_valid_w || !out_stall;
  assign in_stall = !adv;

  assign div[LN_ROW] = cfg.mode ? (DW'({cfg.h, 1'b0}) + DW'(cfg.h)) : DW'(cfg.h);
  assign div[LN_C0]  = DW'(cfg.w);
  assign div[LN_C1]  = DW'({cfg.w, 1'b0});

  assign vld[0] = in_valid;
  assign stg[0][LN_ROW] = '{rem: '0,
                            num: (cfg.mode ? DW'({in_point_y, 2'b00}) : DW'(in_point_y)),
                            quo: '0};
  assign stg[0][LN_C0]  = '{rem: '0, num: DW'(in_point_x), quo: '0};
  assign stg[0][LN_C1]  = '{rem: '0, num: (DW'({in_point_x, 1'b0}) + DW'(cfg.w)), quo: '0};

  for (genvar i = 0; i < DW; i++) begin : g_cell
    hot_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .div   (div),
      .vld_i (vld[i]),
      .stg_i (stg[i]),
      .vld_o (vld[i+1]),
      .stg_o (stg[i+1])
    );
  end

  hot_fix u_fix (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .cfg       (cfg),
    .vld_i     (vld[DW]),
    .stg_i     (stg[DW]),
    .out_valid (out_valid_w),
    .tile_row  (out_tile_row),
    .tile_col  (out_tile_col)
  );
endmodule

/* src/hot_cell.sv */
// One restoring-division step for all lanes, registered toward the next cell.
`timescale 1ns / 1ps
module hot_cell (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic [hot_pkg::NLANE-1:0][hot_pkg::DW-1:0] div,
  input  logic                                  vld_i,
  input  hot_pkg::hot_stage_t                   stg_i,
  output logic                                  vld_o,
  output hot_pkg::hot_stage_t                   stg_o
);
  import hot_pkg::*;

  logic       vld_r;
  hot_stage_t stg_r;
  hot_stage_t stg_nxt;

  always_comb begin
    logic [DW:0] t;
    logic        ge;
    for (int l = 0; l < NLANE; l++) begin
      t  = {stg_i[l].rem, stg_i[l].num[DW-1]};
      ge = (t >= {1'b0, div[l]});
      stg_nxt[l].rem = ge ? DW'(t - {1'b0, div[l]}) : t[DW-1:0];
      stg_nxt[l].num = {stg_i[l].num[DW-2:0], 1'b0};
      stg_nxt[l].quo = {stg_i[l].quo[DW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r <= stg_nxt;
    end
  end

  assign vld_o = vld_r;
  assign stg_o = stg_r;
endmodule

/* src/hot_fix.sv */
// Hexagon edge test, row/column correction, saturation and output register.
`timescale 1ns / 1ps
module hot_fix (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  hot_pkg::hot_cfg_t           cfg,
  input  logic                        vld_i,
  input  hot_pkg::hot_stage_t         stg_i,
  output logic                        out_valid,
  output logic [hot_pkg::ROW_W-1:0]   tile_row,
  output logic [hot_pkg::COL_W-1:0]   tile_col
);
  import hot_pkg::*;

  localparam int LXW = DW + 2;
  localparam int CW  = DW + 2;
  localparam int RW  = DW + 1;
  localparam int PW  = CFG_W + DW + 3;

  logic                  odd;
  logic [LXW-1:0]        lx;
  logic signed [CW-1:0]  chex;
  logic [PW-1:0]         pa, pb, pc;

  logic                  p1_v_r;
  logic [PW-1:0]         a_r, b_r, c_r;
  logic                  near_r, left_r, odd_r;
  logic [DW-1:0]         row_r;
  logic signed [CW-1:0]  col_r;

  logic                  hit_l, hit_r, up;
  logic signed [RW-1:0]  row_s;
  logic signed [CW-1:0]  col_s;

  logic                  out_valid_r;
  logic [ROW_W-1:0]      tile_row_r, tile_row_nxt;
  logic [COL_W-1:0]      tile_col_r, tile_col_nxt;

  // stage 1: local frame of the estimated cell and the cross products
  assign odd  = stg_i[LN_ROW].quo[0];
  assign lx   = odd ? LXW'({stg_i[LN_C1].rem, 1'b0}) : LXW'({stg_i[LN_C0].rem, 2'b00});
  assign chex = odd ? $signed(CW'(stg_i[LN_C1].quo)) - $signed(CW'(1))
                    : $signed(CW'(stg_i[LN_C0].quo));
  assign pa   = PW'({cfg.w, 1'b0}) * PW'(stg_i[LN_ROW].rem);
  assign pb   = PW'(cfg.h) * PW'(lx);
  assign pc   = PW'({cfg.w, 1'b0}) * PW'(cfg.h);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      p1_v_r      <= vld_i;
      out_valid_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r        <= pa;
      b_r        <= pb;
      c_r        <= pc;
      near_r     <= cfg.mode && (stg_i[LN_ROW].rem < DW'(cfg.h));
      left_r     <= lx < LXW'({cfg.w, 1'b0});
      odd_r      <= odd;
      row_r      <= stg_i[LN_ROW].quo;
      col_r      <= cfg.mode ? chex : $signed(CW'(stg_i[LN_C0].quo));
      tile_row_r <= tile_row_nxt;
      tile_col_r <= tile_col_nxt;
    end
  end

  // stage 2: above an upper edge moves to the row above
  assign hit_l = ({1'b0, a_r} + {1'b0, b_r}) < {1'b0, c_r};
  assign hit_r = ({1'b0, a_r} + {1'b0, c_r}) < {1'b0, b_r};
  assign up    = near_r && (left_r ? hit_l : hit_r);

  always_comb begin
    row_s = $signed({1'b0, row_r}) - (up ? $signed(RW'(1)) : $signed(RW'(0)));
    col_s = col_r;
    if (up && left_r && !odd_r) begin
      col_s = col_r - $signed(CW'(1));
    end else if (up && !left_r && odd_r) begin
      col_s = col_r + $signed(CW'(1));
    end
    tile_row_nxt = (row_s > $signed(RW'(ROW_MAX))) ? ROW_W'(ROW_MAX) : row_s[ROW_W-1:0];
    tile_col_nxt = (col_s > $signed(CW'(COL_MAX))) ? COL_W'(COL_MAX) : col_s[COL_W-1:0];
  end

  assign out_valid = out_valid_r;
  assign tile_row  = tile_row_r;
  assign tile_col  = tile_col_r;
endmodule

/* src/hot_chk.sv */
// Port-level checks for the tile hit test, bound to the top level.
`timescale 1ns / 1ps
module hot_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [hot_pkg::ROW_W-1:0]     out_tile_row,
  input logic [hot_pkg::COL_W-1:0]     out_tile_col
);
  import hot_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tile_row) && $stable(out_tile_col))
    else $error("stalled output word changed");

  a_bp: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back pressure");

  a_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_tile_row[ROW_W-1] || (&out_tile_row))
    else $error("row below -1");

  a_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_tile_col[COL_W-1] || (&out_tile_col))
    else $error("column below -1");
endmodule

bind hex_or_rect_tile_hit_test_top hot_chk u_hot_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_tile_row (out_tile_row),
  .out_tile_col (out_tile_col)
);

/* sim/tb.sv */
// Self-checking testbench for the rectangle / offset-hexagon tile hit test.
`timescale 1ns / 1ps
module tb;
  import hot_pkg::*;

  typedef struct {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } tile_hit_t;

  typedef struct {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
  } point_t;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CB-1:0] in_point_x = '0;
  logic [CB-1:0] in_point_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ROW_W-1:0] out_tile_row;
  logic [COL_W-1:0] out_tile_col;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_MODE;
  logic [CFG_W-1:0] cfg_wdata = '0;

  hex_or_rect_tile_hit_test_top u_dut (.*);

  always #6 clk = ~clk;

  // shadow copy of the block's config
  bit cur_mode = 1'b0;
  logic [CFG_W-1:0] cur_w = 16'd256;
  logic [CFG_W-1:0] cur_h = 16'd256;

  point_t pending_pts[$];
  tile_hit_t expected_hits[$];
  int tx_idle = 0, rx_idle = 0;
  bit long_hold_req = 0, long_hold_done = 0;
  int hold_cnt = 0;
  bit took = 0;
  int errors = 0, checked = 0, cycles = 0;

  function automatic tile_hit_t hit_predict(bit mode, logic [CFG_W-1:0] wr, logic [CFG_W-1:0] hr,
                                            logic [CB-1:0] px, logic [CB-1:0] py);
    longint w, h, x, y, r, c, ox, lx, ly;
    bit odd;
    tile_hit_t t;
    w = (wr == 0) ? 1 : longint'(wr);
    h = (hr == 0) ? 1 : longint'(hr);
    x = longint'(px);
    y = longint'(py);
    if (!mode) begin
      r = y / h;
      c = x / w;
    end else begin
      // four times the scale keeps 3/4, 1/4 and 1/2 cell exact
      r = (4 * y) / (3 * h);
      odd = r[0];
      ox = 4 * x - (odd ? 2 * w : 0);
      c = (ox < 0) ? -1 : ox / (4 * w);
      lx = ox - c * 4 * w;
      ly = 4 * y - r * 3 * h;
      if (ly < h) begin
        if (lx < 2 * w) begin
          if (2 * w * ly + h * lx < 2 * w * h) begin
            if (!odd) c = c - 1;
            r = r - 1;
          end
        end else if (2 * w * ly + 2 * w * h < h * lx) begin
          if (odd) c = c + 1;
          r = r - 1;
        end
      end
    end
    if (r > ROW_MAX) r = ROW_MAX;
    if (c > COL_MAX) c = COL_MAX;
    t.row = r[ROW_W-1:0];
    t.col = c[COL_W-1:0];
    return t;
  endfunction

  // driver: one nonblocking write per signal per step
  always @(negedge clk) begin
    bit nv;
    point_t p;
    nv = in_valid;
    p.x = in_point_x;
    p.y = in_point_y;
    if (!in_valid || took) begin
      nv = 0;
      if (rst_n && pending_pts.size() > 0 && $urandom_range(0, 99) >= tx_idle) begin
        p = pending_pts.pop_front();
        nv = 1;
      end
    end
    in_valid <= nv;
    in_point_x <= p.x;
    in_point_y <= p.y;
  end

  // receiver stall, with one long hold-off counted here
  always @(negedge clk) begin
    if (long_hold_req && !long_hold_done) begin
      hold_cnt = 300;
      long_hold_done = 1;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    tile_hit_t e;
    cycles <= cycles + 1;
    took <= in_valid && !in_stall && rst_n;
    if (rst_n && in_valid && !in_stall)
      expected_hits.push_back(hit_predict(cur_mode, cur_w, cur_h, in_point_x, in_point_y));
    if (rst_n && out_valid && !out_stall) begin
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected word row=%0d col=%0d", $time,
                 $signed(out_tile_row), $signed(out_tile_col));
        errors++;
      end else begin
        e = expected_hits.pop_front();
        checked++;
        if (out_tile_row !== e.row) begin
          $display("%0t: tile_row expected %0d actual %0d", $time,
                   $signed(e.row), $signed(out_tile_row));
          errors++;
        end
        if (out_tile_col !== e.col) begin
          $display("%0t: tile_col expected %0d actual %0d", $time,
                   $signed(e.col), $signed(out_tile_col));
          errors++;
        end
      end
    end
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout", $time);
      $display("FAIL hex_or_rect_tile_hit_test_top");
      $finish;
    end
  end

  task automatic add_point(int x, int y);
    point_t p;
    p.x = x[CB-1:0];
    p.y = y[CB-1:0];
    pending_pts.push_back(p);
  endtask

  task automatic wait_idle();
    while (pending_pts.size() > 0 || expected_hits.size() > 0 || in_valid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODE:  cur_mode = val[0];
      REG_WIDTH: cur_w = val;
      default:   cur_h = val;
    endcase
  endtask

  function automatic int near_edge(int span);
    int k, v;
    if (span == 0) span = 1;
    k = $urandom_range(0, 8);
    // multiples of a quarter cell, give or take a few units
    v = (k * span) / 4 + $urandom_range(0, 6) - 3;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v;
  endfunction

  int cfg_mode_l[10] = '{0, 1, 1, 0, 1, 1, 0, 1, 0, 1};
  int cfg_w_l[10]    = '{256, 256, 1, 65535, 65535, 0, 1, 37, 100, 3};
  int cfg_h_l[10]    = '{256, 256, 1, 65535, 65535, 0, 1, 23, 7, 65535};

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 10; ph++) begin
      if (ph > 0) begin
        wait_idle();
        write_reg(REG_MODE, CFG_W'(cfg_mode_l[ph]));
        write_reg(REG_WIDTH, CFG_W'(cfg_w_l[ph]));
        write_reg(REG_HEIGHT, CFG_W'(cfg_h_l[ph]));
      end
      tx_idle = (ph < 3) ? 31 : (ph < 6) ? 53 : 0;
      rx_idle = (ph < 3) ? 53 : (ph < 6) ? 31 : 0;
      if (ph == 7) long_hold_req = 1;
      if (ph <= 2) begin
        // corners, cell edges and slanted-edge neighborhoods
        add_point(0, 0);
        add_point(65535, 65535);
        add_point(0, 65535);
        add_point(65535, 0);
        add_point(255, 255);
        add_point(256, 256);
        add_point(128, 0);
        add_point(0, 63);
        add_point(0, 64);
        add_point(255, 63);
        add_point(128, 191);
        add_point(127, 200);
      end
      for (int i = 0; i < 60; i++) begin
        if ($urandom_range(0, 9) < 7)
          add_point($urandom_range(0, 65535), $urandom_range(0, 65535));
        else
          add_point(near_edge(cfg_w_l[ph]), near_edge(cfg_h_l[ph]));
      end
    end
    wait_idle();
    $display("Covered %0d hit words over ten tile configs, rectangle and hexagon,", checked);
    $display("including unit, zero and full-range cell sizes and row saturation.");
    if (errors == 0) begin
      $display("PASS hex_or_rect_tile_hit_test_top");
    end else begin
      $display("FAIL hex_or_rect_tile_hit_test_top");
    end
    $finish;
  end
endmodule
